>>> rtl/lob_pkg.sv
// Shared types, codes and sizes of the limit order book matcher.
// Depends on nothing; used by lob_table and limit_order_book_matcher.
package lob_pkg;

	localparam int LOB_MAX_ORDERS = 32;
	localparam int CNT_W          = 6;
	localparam int SUM_W          = 32 + CNT_W;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;
	localparam logic [1:0] CMD_EOD    = 2'd3;

	localparam logic [2:0] TYPE_GTC = 3'd0;
	localparam logic [2:0] TYPE_FAK = 3'd1;
	localparam logic [2:0] TYPE_FOK = 3'd2;
	localparam logic [2:0] TYPE_GFD = 3'd3;
	localparam logic [2:0] TYPE_MKT = 3'd4;

	localparam logic [2:0] STS_OK    = 3'd0;
	localparam logic [2:0] STS_DUP   = 3'd1;
	localparam logic [2:0] STS_NOLIQ = 3'd2;
	localparam logic [2:0] STS_CROSS = 3'd3;
	localparam logic [2:0] STS_FILL  = 3'd4;
	localparam logic [2:0] STS_FULL  = 3'd5;
	localparam logic [2:0] STS_UNK   = 3'd6;

	localparam logic KIND_TRADE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic SIDE_BUY = 1'b0;

	localparam logic [CNT_W-1:0] TRADE_CAP = CNT_W'(63);

	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        order_id;
		logic [2:0]         order_type;
		logic               side;
		logic signed [31:0] limit_price;
		logic [31:0]        order_quantity;
	} lob_req_t;

	typedef struct packed {
		logic               kind;
		logic [31:0]        bid_id;
		logic signed [31:0] bid_level;
		logic [31:0]        ask_id;
		logic signed [31:0] ask_level;
		logic [31:0]        traded_quantity;
		logic [2:0]         status;
		logic [CNT_W-1:0]   resting_count;
		logic               last;
	} lob_res_t;

	typedef struct packed {
		logic [31:0]        id;
		logic               side;
		logic signed [31:0] price;
		logic [31:0]        remaining;
		logic [2:0]         kind;
		logic [31:0]        arrival;
	} lob_entry_t;

	typedef struct packed {
		logic en_all;
		logic en_rem;
		logic en_clr;
	} lob_wr_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FIND, ST_FDEC, ST_CHECK, ST_CDEC, ST_INSERT, ST_MSCAN,
		ST_MDEC, ST_TRD_B, ST_TRD_A, ST_FAKCUT, ST_EOD, ST_STAT
	} lob_state_t;

endpackage

>>> rtl/limit_order_book_matcher.sv
// Limit order book matcher: sequencer and shared scan/compare datapath.
// Depends on lob_pkg and lob_table.
//
// channel   handshake            payload
// command   start & !busy        req (lob_req_t)
// result    strobe, one cycle    res (lob_res_t)
//
// Every pass reads one slot a cycle (N = MAX_ORDERS) through the single table
// read port, then decides. Add: find, check, insert, then per trade a match pass
// with TRD_B, TRD_A; a last match pass, FAK cut. Cancel: find. End of day: a pass.
// Reset empties the book at once. The result side cannot stall.
module limit_order_book_matcher import lob_pkg::*; #(
	parameter int MAX_ORDERS = LOB_MAX_ORDERS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  lob_req_t req,
	output logic     strobe,
	output lob_res_t res
);

	localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ORDERS - 1);

	lob_state_t state_q, state_d;
	lob_req_t   req_q;
	logic [IW-1:0] idx_q, fidx_q, free_q, bidx_q, aidx_q;
	logic       found_q, free_found_q, any_q, anyx_q, bf_q, af_q, strobe_q;
	logic [2:0] kind_q, fkind_q, status_q;
	logic signed [31:0] min_q, max_q, price_q, bprice_q, aprice_q;
	logic [31:0] bage_q, aage_q, bid_q, aid_q, brem_q, arem_q, q_q, arr_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] ntr_q, count_q;
	lob_res_t   res_q;

	logic [IW-1:0] rd_idx, wr_idx;
	logic          rd_valid;
	lob_entry_t    rd_entry, wr_entry;
	lob_wr_t       wr;
	logic          cnt_inc, cnt_dec, scan_last;
	logic [31:0]   age, trd_q, rem_left;
	logic          is_opp, crossx, fak_x, hit, bbetter, abetter;
	logic [2:0]    cdec_status;
	logic          accept;

	lob_table #(.MAX_ORDERS(MAX_ORDERS)) u_table (
		.clk(clk), .arst_n(arst_n), .rd_idx(rd_idx), .rd_valid(rd_valid),
		.rd_entry(rd_entry), .wr(wr), .wr_idx(wr_idx), .wr_entry(wr_entry)
	);

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign scan_last = (idx_q == LAST_IDX);
	assign age       = arr_q - rd_entry.arrival;
	assign hit       = rd_valid && (rd_entry.id == req_q.order_id);
	assign is_opp    = rd_valid && (rd_entry.side != req_q.side);
	assign crossx    = (req_q.side == SIDE_BUY) ? (req_q.limit_price >= rd_entry.price)
	                                            : (req_q.limit_price <= rd_entry.price);
	assign fak_x     = (req_q.side == SIDE_BUY) ? (req_q.limit_price >= min_q)
	                                            : (req_q.limit_price <= max_q);
	assign bbetter   = !bf_q || (rd_entry.price > bprice_q) ||
	                   ((rd_entry.price == bprice_q) && (age > bage_q));
	assign abetter   = !af_q || (rd_entry.price < aprice_q) ||
	                   ((rd_entry.price == aprice_q) && (age > aage_q));
	assign trd_q     = (brem_q < arem_q) ? brem_q : arem_q;
	assign rem_left  = (state_q == ST_TRD_B) ? (brem_q - trd_q) : (arem_q - q_q);

	always_comb begin
		priority if (kind_q == TYPE_MKT && !any_q) cdec_status = STS_NOLIQ;
		else if (kind_q == TYPE_FAK && (!any_q || !fak_x)) cdec_status = STS_CROSS;
		else if (kind_q == TYPE_FOK &&
		         (!anyx_q || sum_q < SUM_W'(req_q.order_quantity))) cdec_status = STS_FILL;
		else if (!free_found_q) cdec_status = STS_FULL;
		else cdec_status = STS_OK;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = (req.cmd == CMD_EOD) ? ST_EOD : ST_FIND;
			ST_FIND: if (scan_last) state_d = ST_FDEC;
			ST_FDEC: begin
				priority if (!found_q || req_q.cmd == CMD_CANCEL) state_d = ST_STAT;
				else state_d = ST_CHECK;
				if (req_q.cmd == CMD_ADD) state_d = found_q ? ST_STAT : ST_CHECK;
			end
			ST_CHECK: if (scan_last) state_d = ST_CDEC;
			ST_CDEC: state_d = (cdec_status == STS_OK) ? ST_INSERT : ST_STAT;
			ST_INSERT: state_d = ST_MSCAN;
			ST_MSCAN: if (scan_last) state_d = ST_MDEC;
			ST_MDEC: state_d = (bf_q && af_q && bprice_q >= aprice_q) ? ST_TRD_B : ST_FAKCUT;
			ST_TRD_B: state_d = ST_TRD_A;
			ST_TRD_A: state_d = ST_MSCAN;
			ST_FAKCUT: state_d = ST_STAT;
			ST_EOD: if (scan_last) state_d = ST_STAT;
			ST_STAT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_idx   = (state_q == ST_FAKCUT) ? free_q : idx_q;
		wr       = '0;
		wr_idx   = idx_q;
		wr_entry = '{id: req_q.order_id, side: req_q.side, price: price_q,
		             remaining: req_q.order_quantity, kind: kind_q, arrival: arr_q};
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		unique case (state_q)
			ST_FDEC: begin
				wr_idx = fidx_q;
				if (found_q && req_q.cmd != CMD_ADD) begin
					wr.en_clr = 1'b1;
					cnt_dec   = 1'b1;
				end
			end
			ST_INSERT: begin
				wr_idx    = free_q;
				wr.en_all = 1'b1;
				cnt_inc   = 1'b1;
			end
			ST_TRD_B, ST_TRD_A: begin
				wr_idx             = (state_q == ST_TRD_B) ? bidx_q : aidx_q;
				wr_entry.remaining = rem_left;
				wr.en_rem          = (rem_left != '0);
				wr.en_clr          = (rem_left == '0);
				cnt_dec            = (rem_left == '0);
			end
			ST_FAKCUT: begin
				wr_idx = free_q;
				if (kind_q == TYPE_FAK && rd_valid) begin
					wr.en_clr = 1'b1;
					cnt_dec   = 1'b1;
				end
			end
			ST_EOD: begin
				if (rd_valid && rd_entry.kind == TYPE_GFD) begin
					wr.en_clr = 1'b1;
					cnt_dec   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			arr_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == ST_STAT) || (state_q == ST_TRD_B && ntr_q != TRADE_CAP);
			if (cnt_inc) count_q <= count_q + 1'b1;
			else if (cnt_dec) count_q <= count_q - 1'b1;
			if (state_q == ST_INSERT) arr_q <= arr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIND || state_q == ST_CHECK || state_q == ST_MSCAN ||
		    state_q == ST_EOD) idx_q <= scan_last ? '0 : idx_q + 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_q        <= req;
				idx_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				any_q        <= 1'b0;
				anyx_q       <= 1'b0;
				sum_q        <= '0;
				ntr_q        <= '0;
				bf_q         <= 1'b0;
				af_q         <= 1'b0;
				status_q     <= STS_OK;
				kind_q       <= (req.order_type > TYPE_MKT) ? TYPE_GTC : req.order_type;
				price_q      <= req.limit_price;
			end
			ST_FIND: if (hit) begin
				found_q <= 1'b1;
				fidx_q  <= idx_q;
				fkind_q <= rd_entry.kind;
			end
			ST_FDEC: begin
				if (!found_q) status_q <= (req_q.cmd == CMD_ADD) ? STS_OK : STS_UNK;
				else if (req_q.cmd == CMD_ADD) status_q <= STS_DUP;
				if (req_q.cmd == CMD_MODIFY) kind_q <= fkind_q;
			end
			ST_CHECK: begin
				if (!rd_valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= idx_q;
				end
				if (is_opp) begin
					any_q <= 1'b1;
					if (!any_q || rd_entry.price < min_q) min_q <= rd_entry.price;
					if (!any_q || rd_entry.price > max_q) max_q <= rd_entry.price;
					if (crossx) begin
						anyx_q <= 1'b1;
						sum_q  <= sum_q + SUM_W'(rd_entry.remaining);
					end
				end
			end
			ST_CDEC: begin
				status_q <= cdec_status;
				if (kind_q == TYPE_MKT) begin
					kind_q  <= TYPE_GTC;
					price_q <= (req_q.side == SIDE_BUY) ? max_q : min_q;
				end
			end
			ST_MSCAN: begin
				if (rd_valid && rd_entry.side == SIDE_BUY && bbetter) begin
					bf_q <= 1'b1; bidx_q <= idx_q; bprice_q <= rd_entry.price;
					bage_q <= age; bid_q <= rd_entry.id; brem_q <= rd_entry.remaining;
				end
				if (rd_valid && rd_entry.side != SIDE_BUY && abetter) begin
					af_q <= 1'b1; aidx_q <= idx_q; aprice_q <= rd_entry.price;
					aage_q <= age; aid_q <= rd_entry.id; arem_q <= rd_entry.remaining;
				end
			end
			ST_TRD_B: begin
				q_q <= trd_q;
				if (ntr_q != TRADE_CAP) ntr_q <= ntr_q + 1'b1;
				res_q <= '{kind: KIND_TRADE, bid_id: bid_q, bid_level: bprice_q,
				           ask_id: aid_q, ask_level: aprice_q, traded_quantity: trd_q,
				           status: STS_OK, resting_count: '0, last: 1'b0};
			end
			ST_TRD_A: begin
				bf_q <= 1'b0;
				af_q <= 1'b0;
			end
			ST_STAT: res_q <= '{kind: KIND_STATUS, bid_id: '0, bid_level: '0, ask_id: '0,
			                    ask_level: '0, traded_quantity: '0, status: status_q,
			                    resting_count: count_q, last: 1'b1};
			default: ;
		endcase
	end

	assign strobe = strobe_q;
	assign res    = res_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ORDERS)) else $error("resting count above table size");
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> ($past(state_q) == ST_STAT || $past(state_q) == ST_TRD_B))
		else $error("result strobe without source");
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && res_q.last |-> res_q.kind == KIND_STATUS)
		else $error("last flag on a trade record");
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INSERT |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not raise resting count");
	a_stat_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STAT |=> strobe_q && !busy)
		else $error("status transaction not delivered");
`endif

endmodule

>>> rtl/lob_table.sv
// Order slot table: valid bits with reset, slot fields without.
// One read port, one write port. Depends on lob_pkg.
module lob_table import lob_pkg::*; #(
	parameter int MAX_ORDERS = LOB_MAX_ORDERS,
	localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] rd_idx,
	output logic          rd_valid,
	output lob_entry_t    rd_entry,
	input  lob_wr_t       wr,
	input  logic [IW-1:0] wr_idx,
	input  lob_entry_t    wr_entry
);

	logic       valid_q [MAX_ORDERS];
	lob_entry_t entry_q [MAX_ORDERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ORDERS; i++) valid_q[i] <= 1'b0;
		end else begin
			if (wr.en_all) valid_q[wr_idx] <= 1'b1;
			else if (wr.en_clr) valid_q[wr_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en_all) entry_q[wr_idx] <= wr_entry;
		else if (wr.en_rem) entry_q[wr_idx].remaining <= wr_entry.remaining;
	end

	assign rd_valid = valid_q[rd_idx];
	assign rd_entry = entry_q[rd_idx];

endmodule
